FILE: rtl/mars_pkg.sv
// Package for the machine auxiliary relay sequencer: event codes, letters, register indexes.
package mars_pkg;

  // Event codes carried in cmd
  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_STATUS = 3'd1,
    CMD_MCODE  = 3'd2,
    CMD_TOGGLE = 3'd3,
    CMD_LINK   = 3'd4
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_FLASH_ON_ALARM   = 3'd0,
    REG_LIGHTS_FOLLOW    = 3'd1,
    REG_VACUUM_FOLLOW    = 3'd2,
    REG_SIMULATION_MODE  = 3'd3,
    REG_ALARM_ON_TIME    = 3'd4,
    REG_ALARM_OFF_TIME   = 3'd5,
    REG_COOLER_DELAY     = 3'd6
  } reg_index_t;

  localparam int CmdWidth    = 3;
  localparam int ArgWidth    = 7;
  localparam int TimeWidth   = 32;
  localparam int DelayWidth  = 16;

  // Controller status letters (ASCII)
  localparam logic [ArgWidth-1:0] ST_ALARM = 7'h41;
  localparam logic [ArgWidth-1:0] ST_IDLE  = 7'h49;
  localparam logic [ArgWidth-1:0] ST_RUN   = 7'h52;
  localparam logic [ArgWidth-1:0] ST_JOG   = 7'h4A;
  localparam logic [ArgWidth-1:0] ST_SLEEP = 7'h53;

  // Spindle M-codes
  localparam logic [ArgWidth-1:0] MC_PAUSE     = 7'd0;
  localparam logic [ArgWidth-1:0] MC_START_CW  = 7'd3;
  localparam logic [ArgWidth-1:0] MC_START_CCW = 7'd4;
  localparam logic [ArgWidth-1:0] MC_STOP      = 7'd5;
  localparam logic [ArgWidth-1:0] MC_TOOL      = 7'd6;

  // Manual toggle targets
  localparam logic [ArgWidth-1:0] TGT_LIGHTS = 7'd0;
  localparam logic [ArgWidth-1:0] TGT_COOLER = 7'd1;
  localparam logic [ArgWidth-1:0] TGT_VACUUM = 7'd2;

  // Register reset values
  localparam logic [DelayWidth-1:0] ALARM_ON_TIME_RST  = 16'd5000;
  localparam logic [DelayWidth-1:0] ALARM_OFF_TIME_RST = 16'd1000;
  localparam logic [DelayWidth-1:0] COOLER_DELAY_RST   = 16'd1000;

endpackage

FILE: rtl/machine_auxiliary_relay_sequencer.sv
// Top level of the machine auxiliary relay sequencer: event register, relay update, result register.
//
// Usage:
//   Events enter on in_valid/in_ready with cmd and argument (tick, status letter,
//   spindle M-code, manual toggle, link change). Every event gives exactly one
//   result beat on out_valid/out_ready: the three relay states after the event
//   and drop_spindle_word, set for a spindle start while simulation mode is on.
//   Registers are written on cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high and writes to index 7 are ignored.
// Timing:
//   An accepted event is held in the event register, then its update of time,
//   deadlines, status and relays is done combinationally and lands in the
//   result register, which raises out_valid. One event per cycle is sustained
//   while the receiver does not stall; the rate is set by the single relay
//   update step, which reads the state that the previous event just wrote.
// Reset and stall:
//   rst (synchronous) clears time, deadlines and relays, sets status to idle
//   and loads the register defaults. If the receiver stalls, the result is held
//   and one more event is still taken into the event register; in_ready then
//   drops until the result beat moves.
module machine_auxiliary_relay_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mars_pkg::CmdWidth-1:0] cmd,
  input  logic [mars_pkg::ArgWidth-1:0] argument,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          lights_on,
  output logic                          vacuum_on,
  output logic                          cooler_on,
  output logic                          drop_spindle_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [mars_pkg::DelayWidth-1:0] cfg_data
);

  // Configuration registers
  logic                            flash_on_alarm;
  logic                            lights_follow_spindle;
  logic                            vacuum_follow_spindle;
  logic                            simulation_mode;
  logic [mars_pkg::DelayWidth-1:0] alarm_on_time;
  logic [mars_pkg::DelayWidth-1:0] alarm_off_time;
  logic [mars_pkg::DelayWidth-1:0] cooler_delay;

  // Block state
  logic [mars_pkg::TimeWidth-1:0] time_now, time_now_next;
  logic [mars_pkg::TimeWidth-1:0] flash_deadline, flash_deadline_next;
  logic [mars_pkg::TimeWidth-1:0] cooler_deadline, cooler_deadline_next;
  logic [mars_pkg::ArgWidth-1:0]  machine_status, machine_status_next;
  logic                           lights_relay, lights_relay_next;
  logic                           vacuum_relay, vacuum_relay_next;
  logic                           cooler_relay, cooler_relay_next;
  logic                           drop_next;

  // Event register
  logic                          hold_valid;
  logic [mars_pkg::CmdWidth-1:0] hold_cmd;
  logic [mars_pkg::ArgWidth-1:0] hold_arg;

  logic advance;
  logic cooler_set;
  logic [mars_pkg::TimeWidth-1:0] cooler_cand;

  assign cfg_ready = 1'b1;
  assign advance   = hold_valid && (!out_valid || out_ready);
  assign in_ready  = !hold_valid || advance;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      flash_on_alarm        <= 1'b1;
      lights_follow_spindle <= 1'b0;
      vacuum_follow_spindle <= 1'b0;
      simulation_mode       <= 1'b0;
      alarm_on_time         <= mars_pkg::ALARM_ON_TIME_RST;
      alarm_off_time        <= mars_pkg::ALARM_OFF_TIME_RST;
      cooler_delay          <= mars_pkg::COOLER_DELAY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        mars_pkg::REG_FLASH_ON_ALARM:  flash_on_alarm        <= cfg_data[0];
        mars_pkg::REG_LIGHTS_FOLLOW:   lights_follow_spindle <= cfg_data[0];
        mars_pkg::REG_VACUUM_FOLLOW:   vacuum_follow_spindle <= cfg_data[0];
        mars_pkg::REG_SIMULATION_MODE: simulation_mode       <= cfg_data[0];
        mars_pkg::REG_ALARM_ON_TIME:   alarm_on_time         <= cfg_data;
        mars_pkg::REG_ALARM_OFF_TIME:  alarm_off_time        <= cfg_data;
        mars_pkg::REG_COOLER_DELAY:    cooler_delay          <= cfg_data;
        default: ;
      endcase
    end
  end

  // Event register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      hold_cmd <= cmd;
      hold_arg <= argument;
    end
  end

  // Event action, then status rules
  always_comb begin
    time_now_next        = time_now;
    flash_deadline_next  = flash_deadline;
    machine_status_next  = machine_status;
    lights_relay_next    = lights_relay;
    vacuum_relay_next    = vacuum_relay;
    cooler_relay_next    = cooler_relay;
    drop_next            = 1'b0;
    cooler_set           = 1'b0;

    case (hold_cmd)
      mars_pkg::CMD_TICK: begin
        time_now_next = time_now + 32'd1;
      end
      mars_pkg::CMD_STATUS: begin
        machine_status_next = hold_arg;
      end
      mars_pkg::CMD_MCODE: begin
        if (hold_arg == mars_pkg::MC_START_CW || hold_arg == mars_pkg::MC_START_CCW) begin
          if (vacuum_follow_spindle && !simulation_mode) vacuum_relay_next = 1'b1;
          if (lights_follow_spindle) lights_relay_next = 1'b1;
          drop_next = simulation_mode;
        end else if (hold_arg == mars_pkg::MC_STOP) begin
          if (vacuum_follow_spindle) vacuum_relay_next = 1'b0;
          if (lights_follow_spindle) lights_relay_next = 1'b0;
        end else if (hold_arg == mars_pkg::MC_PAUSE || hold_arg == mars_pkg::MC_TOOL) begin
          if (vacuum_follow_spindle) vacuum_relay_next = 1'b0;
        end
      end
      mars_pkg::CMD_TOGGLE: begin
        if (hold_arg == mars_pkg::TGT_LIGHTS) begin
          lights_relay_next = !lights_relay;
        end else if (hold_arg == mars_pkg::TGT_COOLER) begin
          cooler_relay_next = !cooler_relay;
          cooler_set        = 1'b1;
        end else if (hold_arg == mars_pkg::TGT_VACUUM) begin
          // in alarm the toggle can only switch the vacuum off
          vacuum_relay_next = (machine_status == mars_pkg::ST_ALARM) ? 1'b0 : !vacuum_relay;
        end
      end
      mars_pkg::CMD_LINK: begin
        vacuum_relay_next = 1'b0;
      end
      default: ;
    endcase

    // both the cooler toggle and run/jog load the same deadline
    cooler_cand = time_now_next + {{(mars_pkg::TimeWidth-mars_pkg::DelayWidth){1'b0}},
                                   cooler_delay};

    if (machine_status_next == mars_pkg::ST_SLEEP) begin
      lights_relay_next = 1'b0;
      vacuum_relay_next = 1'b0;
    end else if (machine_status_next == mars_pkg::ST_ALARM) begin
      if (flash_on_alarm && (flash_deadline < time_now_next)) begin
        flash_deadline_next = time_now_next + {{(mars_pkg::TimeWidth-mars_pkg::DelayWidth){1'b0}},
          (lights_relay_next ? alarm_off_time : alarm_on_time)};
        lights_relay_next = !lights_relay_next;
      end
      vacuum_relay_next = 1'b0;
    end else if (machine_status_next == mars_pkg::ST_RUN ||
                 machine_status_next == mars_pkg::ST_JOG) begin
      cooler_relay_next = 1'b1;
      cooler_set        = 1'b1;
    end

    cooler_deadline_next = cooler_set ? cooler_cand : cooler_deadline;

    // cooler off-delay expiry
    if (cooler_relay_next && (cooler_deadline_next < time_now_next)) begin
      cooler_relay_next = 1'b0;
    end
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now        <= '0;
      flash_deadline  <= '0;
      cooler_deadline <= '0;
      machine_status  <= mars_pkg::ST_IDLE;
      lights_relay    <= 1'b0;
      vacuum_relay    <= 1'b0;
      cooler_relay    <= 1'b0;
    end else if (advance) begin
      time_now        <= time_now_next;
      flash_deadline  <= flash_deadline_next;
      cooler_deadline <= cooler_deadline_next;
      machine_status  <= machine_status_next;
      lights_relay    <= lights_relay_next;
      vacuum_relay    <= vacuum_relay_next;
      cooler_relay    <= cooler_relay_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      lights_on         <= lights_relay_next;
      vacuum_on         <= vacuum_relay_next;
      cooler_on         <= cooler_relay_next;
      drop_spindle_word <= drop_next;
    end
  end

  // Checks
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (hold_valid && out_valid && !out_ready))
    else $error("in_ready low without a stalled result");

  a_tick_counts: assert property (@(posedge clk) disable iff (rst)
    (advance && hold_cmd == mars_pkg::CMD_TICK) |=> (time_now == $past(time_now) + 32'd1))
    else $error("tick did not advance time");

  a_sleep_relays_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && machine_status == mars_pkg::ST_SLEEP) |-> (!lights_on && !vacuum_on))
    else $error("lights or vacuum on during sleep");

  a_alarm_vacuum_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && machine_status == mars_pkg::ST_ALARM) |-> !vacuum_on)
    else $error("vacuum on during alarm");

endmodule

FILE: bench/tb.sv
// Testbench for the machine auxiliary relay sequencer: directed table, then random phases.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Unused event codes, an unused register index and an odd argument value
  localparam logic [mars_pkg::CmdWidth-1:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [mars_pkg::CmdWidth-1:0] CMD_LAST_UNUSED  = 3'd7;
  localparam logic [2:0]                    REG_UNUSED       = 3'd7;
  localparam logic [mars_pkg::ArgWidth-1:0] MC_OTHER         = 7'd127;

  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 100;
  localparam int DIR_ROWS      = 33;

  // One result beat: relay states plus the spindle word drop flag
  typedef struct packed {
    logic lights;
    logic vacuum;
    logic cooler;
    logic drop;
  } relay_beat_t;

  // One directed row: an event or a register write
  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  code;
    logic [15:0] value;
    logic        typed;
    relay_beat_t want;
  } stim_row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [mars_pkg::CmdWidth-1:0]   cmd = '0;
  logic [mars_pkg::ArgWidth-1:0]   argument = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            lights_on;
  logic                            vacuum_on;
  logic                            cooler_on;
  logic                            drop_spindle_word;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [2:0]                      cfg_index = '0;
  logic [mars_pkg::DelayWidth-1:0] cfg_data = '0;

  machine_auxiliary_relay_sequencer u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cmd              (cmd),
    .argument         (argument),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .lights_on        (lights_on),
    .vacuum_on        (vacuum_on),
    .cooler_on        (cooler_on),
    .drop_spindle_word(drop_spindle_word),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow registers and relay state of the predictor
  logic                            cf_flash, cf_lights_follow, cf_vacuum_follow, cf_sim;
  logic [mars_pkg::DelayWidth-1:0] cf_on_time, cf_off_time, cf_cooler_delay;
  logic [mars_pkg::TimeWidth-1:0]  now_ms, flash_due, cooler_due;
  logic [mars_pkg::ArgWidth-1:0]   status_q;
  logic                            lights_q, vacuum_q, cooler_q;

  relay_beat_t relay_beats_due[$];
  int          mismatches = 0;
  int          burst_left = 0;
  int          quiet_cycles = 0;
  logic [9:0]  rx_cycle = '0;
  relay_beat_t rx_got, rx_want;

  // Directed rows: reset state, every M-code, toggles, status rules, simulation mode
  stim_row_t dir_table [DIR_ROWS] = '{
    '{1'b0, mars_pkg::CMD_TICK,            16'd0,                        1'b1, 4'b0000},
    '{1'b1, mars_pkg::REG_LIGHTS_FOLLOW,   16'd1,                        1'b0, 4'b0000},
    '{1'b1, mars_pkg::REG_VACUUM_FOLLOW,   16'd1,                        1'b0, 4'b0000},
    '{1'b1, mars_pkg::REG_ALARM_ON_TIME,   16'd2,                        1'b0, 4'b0000},
    '{1'b1, mars_pkg::REG_ALARM_OFF_TIME,  16'd1,                        1'b0, 4'b0000},
    '{1'b1, mars_pkg::REG_COOLER_DELAY,    16'd3,                        1'b0, 4'b0000},
    '{1'b0, mars_pkg::CMD_MCODE,  16'(mars_pkg::MC_START_CW),            1'b1, 4'b1100},
    '{1'b0, mars_pkg::CMD_MCODE,  16'(mars_pkg::MC_PAUSE),               1'b1, 4'b1000},
    '{1'b0, mars_pkg::CMD_MCODE,  16'(mars_pkg::MC_START_CCW),           1'b1, 4'b1100},
    '{1'b0, mars_pkg::CMD_MCODE,  16'(mars_pkg::MC_TOOL),                1'b1, 4'b1000},
    '{1'b0, mars_pkg::CMD_MCODE,  16'(mars_pkg::MC_STOP),                1'b1, 4'b0000},
    '{1'b0, mars_pkg::CMD_MCODE,  16'(MC_OTHER),                         1'b1, 4'b0000},
    '{1'b0, mars_pkg::CMD_TOGGLE, 16'(mars_pkg::TGT_LIGHTS),             1'b1, 4'b1000},
    '{1'b0, mars_pkg::CMD_TOGGLE, 16'(mars_pkg::TGT_VACUUM),             1'b1, 4'b1100},
    '{1'b0, mars_pkg::CMD_LINK,            16'h007F,                     1'b1, 4'b1000},
    '{1'b0, mars_pkg::CMD_TOGGLE, 16'(mars_pkg::TGT_COOLER),             1'b1, 4'b1010},
    '{1'b0, mars_pkg::CMD_STATUS, 16'(mars_pkg::ST_RUN),                 1'b0, 4'b0000},
    '{1'b0, mars_pkg::CMD_STATUS, 16'(mars_pkg::ST_IDLE),                1'b0, 4'b0000},
    '{1'b0, mars_pkg::CMD_TICK,            16'd0,                        1'b0, 4'b0000},
    '{1'b0, mars_pkg::CMD_TICK,            16'd0,                        1'b0, 4'b0000},
    '{1'b0, mars_pkg::CMD_TICK,            16'd0,                        1'b0, 4'b0000},
    '{1'b0, mars_pkg::CMD_TICK,            16'd0,                        1'b0, 4'b0000},
    '{1'b0, mars_pkg::CMD_STATUS, 16'(mars_pkg::ST_ALARM),               1'b0, 4'b0000},
    '{1'b0, mars_pkg::CMD_TOGGLE, 16'(mars_pkg::TGT_VACUUM),             1'b0, 4'b0000},
    '{1'b0, mars_pkg::CMD_TICK,            16'd0,                        1'b0, 4'b0000},
    '{1'b0, mars_pkg::CMD_TICK,            16'd0,                        1'b0, 4'b0000},
    '{1'b0, mars_pkg::CMD_STATUS, 16'(mars_pkg::ST_JOG),                 1'b0, 4'b0000},
    '{1'b0, mars_pkg::CMD_STATUS, 16'(mars_pkg::ST_SLEEP),               1'b0, 4'b0000},
    '{1'b0, mars_pkg::CMD_TOGGLE, 16'(mars_pkg::TGT_LIGHTS),             1'b0, 4'b0000},
    '{1'b0, CMD_LAST_UNUSED,               16'h0055,                     1'b0, 4'b0000},
    '{1'b1, mars_pkg::REG_SIMULATION_MODE, 16'd1,                        1'b0, 4'b0000},
    '{1'b0, mars_pkg::CMD_MCODE,  16'(mars_pkg::MC_START_CW),            1'b0, 4'b0000},
    '{1'b0, mars_pkg::CMD_MCODE,  16'(mars_pkg::MC_START_CCW),           1'b0, 4'b0000}
  };

  // Relay state after one event: event action first, then the status rules
  function automatic relay_beat_t predict_relays(input logic [2:0] c, input logic [6:0] a);
    relay_beat_t r;
    logic        drop;
    drop = 1'b0;
    case (c)
      mars_pkg::CMD_TICK:   now_ms = now_ms + 32'd1;
      mars_pkg::CMD_STATUS: status_q = a;
      mars_pkg::CMD_MCODE: begin
        if (a == mars_pkg::MC_START_CW || a == mars_pkg::MC_START_CCW) begin
          if (cf_vacuum_follow && !cf_sim) vacuum_q = 1'b1;
          if (cf_lights_follow) lights_q = 1'b1;
          drop = cf_sim;
        end else if (a == mars_pkg::MC_STOP) begin
          if (cf_vacuum_follow) vacuum_q = 1'b0;
          if (cf_lights_follow) lights_q = 1'b0;
        end else if (a == mars_pkg::MC_PAUSE || a == mars_pkg::MC_TOOL) begin
          if (cf_vacuum_follow) vacuum_q = 1'b0;
        end
      end
      mars_pkg::CMD_TOGGLE: begin
        if (a == mars_pkg::TGT_LIGHTS) begin
          lights_q = ~lights_q;
        end else if (a == mars_pkg::TGT_COOLER) begin
          cooler_q = ~cooler_q;
          cooler_due = now_ms + {16'd0, cf_cooler_delay};
        end else if (a == mars_pkg::TGT_VACUUM) begin
          vacuum_q = (status_q == mars_pkg::ST_ALARM) ? 1'b0 : ~vacuum_q;
        end
      end
      mars_pkg::CMD_LINK: vacuum_q = 1'b0;
      default: ;
    endcase
    // status rules
    if (status_q == mars_pkg::ST_SLEEP) begin
      lights_q = 1'b0;
      vacuum_q = 1'b0;
    end else if (status_q == mars_pkg::ST_ALARM) begin
      if (cf_flash && flash_due < now_ms) begin
        flash_due = now_ms + {16'd0, lights_q ? cf_off_time : cf_on_time};
        lights_q = ~lights_q;
      end
      vacuum_q = 1'b0;
    end else if (status_q == mars_pkg::ST_RUN || status_q == mars_pkg::ST_JOG) begin
      cooler_q = 1'b1;
      cooler_due = now_ms + {16'd0, cf_cooler_delay};
    end
    if (cooler_q && cooler_due < now_ms) cooler_q = 1'b0;
    r.lights = lights_q;
    r.vacuum = vacuum_q;
    r.cooler = cooler_q;
    r.drop   = drop;
    return r;
  endfunction

  // Present one event beat and hold it until accepted
  task automatic send_event(input logic [2:0] c, input logic [6:0] a,
                            input logic use_typed, input relay_beat_t typed_beat);
    relay_beat_t next_beat;
    in_valid <= 1'b1;
    cmd      <= c;
    argument <= a;
    do @(posedge clk); while (!in_ready);
    next_beat = predict_relays(c, a);
    relay_beats_due.push_back(use_typed ? typed_beat : next_beat);
  endtask

  // Register write; cfg_valid stays high so writes can go back to back
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mars_pkg::REG_FLASH_ON_ALARM:  cf_flash         = data[0];
      mars_pkg::REG_LIGHTS_FOLLOW:   cf_lights_follow = data[0];
      mars_pkg::REG_VACUUM_FOLLOW:   cf_vacuum_follow = data[0];
      mars_pkg::REG_SIMULATION_MODE: cf_sim           = data[0];
      mars_pkg::REG_ALARM_ON_TIME:   cf_on_time       = data;
      mars_pkg::REG_ALARM_OFF_TIME:  cf_off_time      = data;
      mars_pkg::REG_COOLER_DELAY:    cf_cooler_delay  = data;
      default: ;
    endcase
  endtask

  // Stop sending and writing, and let every outstanding result drain
  task automatic wait_idle();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (relay_beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sender bursts: after a burst, maybe a gap with in_valid low
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Result side: check each beat, then pick the next ready value
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1'b1;
    if (!rst && out_valid && out_ready) begin
      rx_got = '{lights: lights_on, vacuum: vacuum_on, cooler: cooler_on,
                 drop: drop_spindle_word};
      if (relay_beats_due.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with none expected, got L%b V%b C%b D%b", $time,
                 rx_got.lights, rx_got.vacuum, rx_got.cooler, rx_got.drop);
      end else begin
        rx_want = relay_beats_due.pop_front();
        if (rx_got !== rx_want) begin
          mismatches++;
          $display("%0t: expected L%b V%b C%b D%b, got L%b V%b C%b D%b", $time,
                   rx_want.lights, rx_want.vacuum, rx_want.cooler, rx_want.drop,
                   rx_got.lights, rx_got.vacuum, rx_got.cooler, rx_got.drop);
        end
      end
    end
    case (rx_cycle[9:8])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= (rx_cycle[2:0] >= 3'd5);  // long stalls
    endcase
  end

  // Watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [6:0][15:0]              cfg_set;
    logic [mars_pkg::CmdWidth-1:0] cmd_r;
    logic [mars_pkg::ArgWidth-1:0] arg_r;
    int unsigned                   pick;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    cf_flash         = 1'b1;
    cf_lights_follow = 1'b0;
    cf_vacuum_follow = 1'b0;
    cf_sim           = 1'b0;
    cf_on_time       = mars_pkg::ALARM_ON_TIME_RST;
    cf_off_time      = mars_pkg::ALARM_OFF_TIME_RST;
    cf_cooler_delay  = mars_pkg::COOLER_DELAY_RST;
    now_ms     = '0;
    flash_due  = '0;
    cooler_due = '0;
    status_q   = mars_pkg::ST_IDLE;
    lights_q   = 1'b0;
    vacuum_q   = 1'b0;
    cooler_q   = 1'b0;

    // directed part
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_table[i].is_cfg) begin
        wait_idle();
        write_reg(dir_table[i].code, dir_table[i].value);
      end else begin
        cfg_valid <= 1'b0;
        send_event(dir_table[i].code, dir_table[i].value[mars_pkg::ArgWidth-1:0],
                   dir_table[i].typed, dir_table[i].want);
        pace();
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      // order of fields: cooler, off, on, sim, vacuum follow, lights follow, flash
      case (ph)
        0: cfg_set = {16'd5, 16'd2, 16'd3, 16'd0, 16'd1, 16'd1, 16'd1};
        1: cfg_set = {16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd1};
        2: cfg_set = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd0, 16'd1, 16'd0};
        default: begin
          for (int r = 0; r < 7; r++) begin
            if (r <= int'(mars_pkg::REG_SIMULATION_MODE))
              cfg_set[r] = {15'($urandom), 1'($urandom)};
            else
              cfg_set[r] = 16'($urandom_range(0, 12));
          end
        end
      endcase
      wait_idle();
      for (int r = 0; r < 7; r++) write_reg(3'(r), cfg_set[r]);
      if (ph == PHASES - 1) write_reg(REG_UNUSED, 16'($urandom));
      cfg_valid <= 1'b0;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick  = $urandom_range(0, 99);
        arg_r = 7'($urandom);
        if (pick < 35) begin
          cmd_r = mars_pkg::CMD_TICK;
        end else if (pick < 55) begin
          cmd_r = mars_pkg::CMD_STATUS;
          case ($urandom_range(0, 9))
            0, 1:    arg_r = mars_pkg::ST_ALARM;
            2:       arg_r = mars_pkg::ST_SLEEP;
            3:       arg_r = mars_pkg::ST_RUN;
            4:       arg_r = mars_pkg::ST_JOG;
            5:       arg_r = mars_pkg::ST_IDLE;
            default: ;
          endcase
        end else if (pick < 75) begin
          cmd_r = mars_pkg::CMD_MCODE;
          case ($urandom_range(0, 9))
            0, 1:    arg_r = mars_pkg::MC_START_CW;
            2:       arg_r = mars_pkg::MC_START_CCW;
            3, 4:    arg_r = mars_pkg::MC_STOP;
            5:       arg_r = mars_pkg::MC_PAUSE;
            6:       arg_r = mars_pkg::MC_TOOL;
            default: ;
          endcase
        end else if (pick < 88) begin
          cmd_r = mars_pkg::CMD_TOGGLE;
          case ($urandom_range(0, 7))
            0, 1:    arg_r = mars_pkg::TGT_LIGHTS;
            2, 3:    arg_r = mars_pkg::TGT_COOLER;
            4, 5:    arg_r = mars_pkg::TGT_VACUUM;
            default: ;
          endcase
        end else if (pick < 94) begin
          cmd_r = mars_pkg::CMD_LINK;
        end else begin
          cmd_r = 3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
        end
        send_event(cmd_r, arg_r, 1'b0, '0);
        pace();
      end
    end

    wait_idle();
    if (mismatches == 0 && relay_beats_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
